### hdl/mm2a_pkg.sv
// shared types and constants for the murmur2a incremental hash core
// no dependencies; used by mm2a_mul and murmur2a_incremental_hash_core

package mm2a_pkg;

    typedef logic [31:0] t_word;

    // mix multiplier and shift amounts
    localparam t_word       MIX_MUL     = 32'h5bd1_e995;
    localparam logic [4:0]  MIX_SHIFT   = 5'd24;
    localparam logic [4:0]  FIN_SHIFT_A = 5'd13;
    localparam logic [4:0]  FIN_SHIFT_B = 5'd15;

endpackage

### hdl/mm2a_mul.sv
// shared registered multiplier: product of one operand and the mix constant
// depends on mm2a_pkg

module mm2a_mul (
    input  logic              i_clk,
    input  mm2a_pkg::t_word   i_operand,
    output mm2a_pkg::t_word   o_product
);

    mm2a_pkg::t_word r_product;
    mm2a_pkg::t_word n_product;

    // low 32 bits of operand times the mix constant
    always_comb begin
        n_product = i_operand * mm2a_pkg::MIX_MUL;
    end

    always_ff @(posedge i_clk) begin
        r_product <= n_product;
    end

    assign o_product = r_product;

endmodule

### hdl/murmur2a_incremental_hash_core.sv
// incremental 32-bit murmur2a hash over a byte stream
// depends on mm2a_pkg and mm2a_mul
// channels: input item (i_valid/o_ready) carries i_data_byte, i_byte_valid,
// i_last; result item (o_valid/i_ready) carries o_hash_value; the seed is
// written through i_cfg_we/i_cfg_data; the user is to write it only at an
// edge the block is idle, which the block itself does not enforce
// a byte that does not complete a 4-byte group is added to the tail and the
// block stays ready; a byte that completes a group starts one mix (three
// multiplies on the shared multiplier and a combine); an item with last adds
// a tail mix, a length mix and an avalanche (after the block mix when it also
// completes a group); o_valid rises in the same cycle the sequencer returns
// to idle for the next item; the rate over a long message is set by the
// single multiplier which every mix step goes through
// o_ready is high only while the sequencer waits for input; the result sits
// in an output register, so the next message may stream in while it waits
// if the receiver stalls, a following last item waits before its avalanche
// until the previous hash is taken
// reset (synchronous, active low) clears the seed to 0, empties the tail,
// zeroes the length and drops any pending result

module murmur2a_incremental_hash_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input item channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_valid,
    input  logic        i_last,
    // result item channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_hash_value,
    // seed register write
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data
);

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_K1   = 3'd1;
    localparam logic [2:0] S_K2   = 3'd2;
    localparam logic [2:0] S_H    = 3'd3;
    localparam logic [2:0] S_X    = 3'd4;
    localparam logic [2:0] S_A1   = 3'd5;
    localparam logic [2:0] S_A2   = 3'd6;

    // which word the current mix folds in
    localparam logic [1:0] P_BLOCK = 2'd0;
    localparam logic [1:0] P_TAIL  = 2'd1;
    localparam logic [1:0] P_LEN   = 2'd2;

    logic [2:0]       r_state;
    logic [1:0]       r_phase;
    logic             r_last;
    logic             r_idle;
    mm2a_pkg::t_word  r_seed;
    mm2a_pkg::t_word  r_hash;
    mm2a_pkg::t_word  r_k;
    mm2a_pkg::t_word  r_tail;
    logic [1:0]       r_cnt;
    mm2a_pkg::t_word  r_len;
    mm2a_pkg::t_word  r_out;
    logic             r_out_valid;

    mm2a_pkg::t_word  n_tail;
    mm2a_pkg::t_word  n_len;
    logic [1:0]       n_cnt;
    logic             w_accept;
    logic             w_full;
    mm2a_pkg::t_word  w_mul_a;
    mm2a_pkg::t_word  w_mul_p;
    mm2a_pkg::t_word  w_byte_shift;

    assign o_ready      = (r_state == S_IDLE);
    assign w_accept     = i_valid && o_ready;
    assign o_valid      = r_out_valid;
    assign o_hash_value = r_out;

    // byte placement into the little-endian tail
    always_comb begin
        w_byte_shift = {24'd0, i_data_byte} << {r_cnt, 3'b000};
        if (i_byte_valid) begin
            n_tail = r_tail | w_byte_shift;
            n_cnt  = r_cnt + 2'd1;
            n_len  = r_len + 32'd1;
        end else begin
            n_tail = r_tail;
            n_cnt  = r_cnt;
            n_len  = r_len;
        end
        w_full = i_byte_valid && (r_cnt == 2'd3);
    end

    // operand for the shared multiplier
    always_comb begin
        unique case (r_state)
            S_K1:    w_mul_a = r_k;
            S_K2:    w_mul_a = w_mul_p ^ (w_mul_p >> mm2a_pkg::MIX_SHIFT);
            S_H:     w_mul_a = r_hash;
            S_A1:    w_mul_a = r_hash ^ (r_hash >> mm2a_pkg::FIN_SHIFT_A);
            default: w_mul_a = r_k;
        endcase
    end

    mm2a_mul u_mul (
        .i_clk     (i_clk),
        .i_operand (w_mul_a),
        .o_product (w_mul_p)
    );

    // sequencer and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= P_BLOCK;
            r_last      <= 1'b0;
            r_idle      <= 1'b1;
            r_seed      <= '0;
            r_hash      <= '0;
            r_tail      <= '0;
            r_cnt       <= '0;
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // result handshake
            if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_len  <= n_len;
                        r_last <= i_last;
                        if (i_byte_valid) begin
                            r_idle <= 1'b0;
                        end
                        if (w_full || i_last) begin
                            r_k     <= n_tail;
                            r_tail  <= '0;
                            r_cnt   <= '0;
                            r_phase <= w_full ? P_BLOCK : P_TAIL;
                            r_state <= S_K1;
                        end else begin
                            r_tail <= n_tail;
                            r_cnt  <= n_cnt;
                        end
                    end
                end
                S_K1: r_state <= S_K2;
                S_K2: r_state <= S_H;
                S_H: begin
                    r_k     <= w_mul_p;
                    r_state <= S_X;
                end
                S_X: begin
                    r_hash <= w_mul_p ^ r_k;
                    unique case (r_phase)
                        P_BLOCK: begin
                            if (r_last) begin
                                r_k     <= r_tail;
                                r_phase <= P_TAIL;
                                r_state <= S_K1;
                            end else begin
                                r_state <= S_IDLE;
                            end
                        end
                        P_TAIL: begin
                            r_k     <= r_len;
                            r_phase <= P_LEN;
                            r_state <= S_K1;
                        end
                        default: r_state <= S_A1;
                    endcase
                end
                S_A1: begin
                    // wait for the output register to free up
                    if (!r_out_valid) begin
                        r_state <= S_A2;
                    end
                end
                S_A2: begin
                    r_out       <= w_mul_p ^ (w_mul_p >> mm2a_pkg::FIN_SHIFT_B);
                    r_out_valid <= 1'b1;
                    r_hash      <= r_seed;
                    r_len       <= '0;
                    r_idle      <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase

            // seed write, reloads the hash between messages
            if (i_cfg_we) begin
                r_seed <= i_cfg_data;
                if (r_idle && (r_state == S_IDLE)) begin
                    r_hash <= i_cfg_data;
                end
            end
        end
    end

    // result is only written into a free output register
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_A2) |-> !r_out_valid)
        else $error("result overwrote a pending item");

    // a last item always starts the finalize sequence
    a_last_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_last) |=> (r_state == S_K1))
        else $error("last item did not start a mix");

    // the tail is empty whenever the sequencer is busy
    a_tail_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> ((r_cnt == 2'd0) && (r_tail == '0)))
        else $error("tail not cleared during a mix");

    // length mix is always followed by the avalanche
    a_len_then_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_X) && (r_phase == P_LEN)) |=> (r_state == S_A1))
        else $error("avalanche did not follow the length mix");

endmodule
